// File: sv/lwc_pkg.sv
// shared constants, codes and helpers for the line window clipper
package lwc_pkg;

  // default coordinate width
  localparam int COORD_BITS_DEF = 16;

  // widest signed value the helpers work on
  localparam int WIDE_BITS = 34;

  // window reset values
  localparam int WIN_LEFT_RST   = 0;
  localparam int WIN_TOP_RST    = 0;
  localparam int WIN_RIGHT_RST  = 639;
  localparam int WIN_BOTTOM_RST = 479;

  // outcode bit positions
  localparam int CODE_TOP    = 0;
  localparam int CODE_BOTTOM = 1;
  localparam int CODE_RIGHT  = 2;
  localparam int CODE_LEFT   = 3;

  // verdict codes
  typedef enum logic [1:0] {
    VERDICT_ACCEPT  = 2'd0,
    VERDICT_REJECT  = 2'd1,
    VERDICT_CLIPPED = 2'd2
  } verdict_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_TOP    = 2'd1,
    REG_RIGHT  = 2'd2,
    REG_BOTTOM = 2'd3
  } reg_idx_t;

  typedef logic signed [WIDE_BITS-1:0] wide_t;

  // four-bit region code of a point against the window
  function automatic logic [3:0] outcode(input wide_t x, input wide_t y,
                                         input wide_t wl, input wide_t wt,
                                         input wide_t wr, input wide_t wb);
    logic [3:0] c;
    c = '0;
    c[CODE_TOP]    = (y < wt);
    c[CODE_BOTTOM] = (y > wb);
    c[CODE_RIGHT]  = (x > wr);
    c[CODE_LEFT]   = (x < wl);
    return c;
  endfunction

endpackage

// File: sv/lwc_cell.sv
// one restoring divide step for all four intersection lanes
module lwc_cell #(
  parameter int W       = 16,
  parameter int SB_BITS = 80
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_i,
  input  logic [3:0][W-1:0]   rem_i,
  input  logic [3:0][W-1:0]   low_i,
  input  logic [3:0][W-1:0]   div_i,
  input  logic [SB_BITS-1:0]  sb_i,
  output logic                vld_o,
  output logic [3:0][W-1:0]   rem_o,
  output logic [3:0][W-1:0]   low_o,
  output logic [3:0][W-1:0]   div_o,
  output logic [SB_BITS-1:0]  sb_o
);

  logic                vld_r;
  logic [3:0][W-1:0]   rem_r, rem_nxt;
  logic [3:0][W-1:0]   low_r, low_nxt;
  logic [3:0][W-1:0]   div_r;
  logic [SB_BITS-1:0]  sb_r;

  // shift in one dividend bit, subtract when it fits
  always_comb begin
    logic [W:0] t;
    logic [W:0] d;
    logic       ge;
    for (int k = 0; k < 4; k++) begin
      t  = {rem_i[k], low_i[k][W-1]};
      d  = {1'b0, div_i[k]};
      ge = (t >= d);
      rem_nxt[k] = ge ? W'(t - d) : t[W-1:0];
      low_nxt[k] = {low_i[k][W-2:0], ge};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      low_r <= low_nxt;
      div_r <= div_i;
      sb_r  <= sb_i;
    end
  end

  assign vld_o = vld_r;
  assign rem_o = rem_r;
  assign low_o = low_r;
  assign div_o = div_r;
  assign sb_o  = sb_r;

endmodule

// File: sv/lwc_prep.sv
// outcodes, operand magnitudes and products ahead of the divider chain
module lwc_prep #(
  parameter int W = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      vld_i,
  input  logic signed [W-1:0]       sx_i,
  input  logic signed [W-1:0]       sy_i,
  input  logic signed [W-1:0]       ex_i,
  input  logic signed [W-1:0]       ey_i,
  input  logic signed [W-1:0]       wl_i,
  input  logic signed [W-1:0]       wt_i,
  input  logic signed [W-1:0]       wr_i,
  input  logic signed [W-1:0]       wb_i,
  output logic                      vld_o,
  output logic [3:0][2*W-1:0]       prod_o,
  output logic [3:0][W-1:0]         div_o,
  output logic [3:0]                neg_o,
  output logic [3:0]                zero_o,
  output logic [3:0]                c1_o,
  output logic [3:0]                c2_o,
  output logic [4*W-1:0]            pts_o
);
  import lwc_pkg::*;

  logic [3:0]          c1, c2;
  logic [3:0][W-1:0]   ma, mb, mc;
  logic [3:0]          neg, zero;

  // stage a registers
  logic                vla_r;
  logic [3:0][W-1:0]   ma_r, mb_r, mc_r;
  logic [3:0]          neg_a_r, zero_a_r, c1_a_r, c2_a_r;
  logic [4*W-1:0]      pts_a_r;

  // stage b registers
  logic                vlb_r;
  logic [3:0][2*W-1:0] prod_r;
  logic [3:0][W-1:0]   mc_b_r;
  logic [3:0]          neg_b_r, zero_b_r, c1_b_r, c2_b_r;
  logic [4*W-1:0]      pts_b_r;

  assign c1 = outcode(WIDE_BITS'(sx_i), WIDE_BITS'(sy_i), WIDE_BITS'(wl_i),
                      WIDE_BITS'(wt_i), WIDE_BITS'(wr_i), WIDE_BITS'(wb_i));
  assign c2 = outcode(WIDE_BITS'(ex_i), WIDE_BITS'(ey_i), WIDE_BITS'(wl_i),
                      WIDE_BITS'(wt_i), WIDE_BITS'(wr_i), WIDE_BITS'(wb_i));

  // lane 0/1: start point y/x move, lane 2/3: end point y/x move
  always_comb begin
    logic signed [W:0] px, py, ox, oy, xe, ye, da, db, dc;
    logic [3:0]        cd;
    for (int k = 0; k < 4; k++) begin
      if (k < 2) begin
        px = (W+1)'(sx_i); py = (W+1)'(sy_i); ox = (W+1)'(ex_i); oy = (W+1)'(ey_i);
        cd = c1;
      end else begin
        px = (W+1)'(ex_i); py = (W+1)'(ey_i); ox = (W+1)'(sx_i); oy = (W+1)'(sy_i);
        cd = c2;
      end
      xe = cd[CODE_RIGHT]  ? (W+1)'(wr_i) : (W+1)'(wl_i);
      ye = cd[CODE_BOTTOM] ? (W+1)'(wb_i) : (W+1)'(wt_i);
      if ((k % 2) == 0) begin
        da = oy - py; db = xe - px; dc = ox - px;
      end else begin
        da = ox - px; db = ye - py; dc = oy - py;
      end
      ma[k]   = da[W] ? W'(-da) : da[W-1:0];
      mb[k]   = db[W] ? W'(-db) : db[W-1:0];
      mc[k]   = dc[W] ? W'(-dc) : dc[W-1:0];
      neg[k]  = da[W] ^ db[W] ^ dc[W];
      zero[k] = (dc == '0);
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vla_r <= 1'b0;
      vlb_r <= 1'b0;
    end else if (en) begin
      vla_r <= vld_i;
      vlb_r <= vla_r;
    end
  end

  // magnitudes, then products
  always_ff @(posedge clk) begin
    if (en) begin
      ma_r     <= ma;
      mb_r     <= mb;
      mc_r     <= mc;
      neg_a_r  <= neg;
      zero_a_r <= zero;
      c1_a_r   <= c1;
      c2_a_r   <= c2;
      pts_a_r  <= {sx_i, sy_i, ex_i, ey_i};
      for (int k = 0; k < 4; k++) begin
        prod_r[k] <= (2*W)'(ma_r[k]) * (2*W)'(mb_r[k]);
      end
      mc_b_r   <= mc_r;
      neg_b_r  <= neg_a_r;
      zero_b_r <= zero_a_r;
      c1_b_r   <= c1_a_r;
      c2_b_r   <= c2_a_r;
      pts_b_r  <= pts_a_r;
    end
  end

  assign vld_o  = vlb_r;
  assign prod_o = prod_r;
  assign div_o  = mc_b_r;
  assign neg_o  = neg_b_r;
  assign zero_o = zero_b_r;
  assign c1_o   = c1_b_r;
  assign c2_o   = c2_b_r;
  assign pts_o  = pts_b_r;

endmodule

// File: sv/line_window_clipper_core.sv
// line window clipper top level: config registers, divider chain, result select
//
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | start and end coordinates
// out     | output    | out_valid/out_stall| verdict and clipped coordinates
// cfg     | input     | psel/penable/pready| window edges
//
// one segment per cycle while no result is held by out_stall; two prep stages,
// one divide cell per quotient bit, one select stage into the output register.
// synchronous reset clears all valid bits and loads the default window.
// a held result stalls the whole pipeline; in_stall follows out_stall then.
module line_window_clipper_core #(
  parameter int COORD_BITS = lwc_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_verdict,
  output logic signed [COORD_BITS-1:0] out_out_start_x,
  output logic signed [COORD_BITS-1:0] out_out_start_y,
  output logic signed [COORD_BITS-1:0] out_out_end_x,
  output logic signed [COORD_BITS-1:0] out_out_end_y,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [3:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import lwc_pkg::*;

  localparam int W       = COORD_BITS;
  localparam int SB_BITS = 4*W + 16;

  logic                adv;
  logic signed [W-1:0] wl_r, wt_r, wr_r, wb_r;
  reg_idx_t            ridx;

  // prep outputs
  logic                pv;
  logic [3:0][2*W-1:0] pprod;
  logic [3:0][W-1:0]   pdiv;
  logic [3:0]          pneg, pzero, pc1, pc2;
  logic [4*W-1:0]      ppts;

  // divider chain
  logic                ch_vld [W+1];
  logic [3:0][W-1:0]   ch_rem [W+1];
  logic [3:0][W-1:0]   ch_low [W+1];
  logic [3:0][W-1:0]   ch_div [W+1];
  logic [SB_BITS-1:0]  ch_sb  [W+1];

  // output register
  logic                out_valid_r;
  verdict_t            verdict_r, verdict_nxt;
  logic [W-1:0]        osx_r, osy_r, oex_r, oey_r;
  logic [W-1:0]        osx_nxt, osy_nxt, oex_nxt, oey_nxt;

  // pipeline moves whenever the result slot is free or its result is taken
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // configuration port
  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r <= W'(WIN_LEFT_RST);
      wt_r <= W'(WIN_TOP_RST);
      wr_r <= W'(WIN_RIGHT_RST);
      wb_r <= W'(WIN_BOTTOM_RST);
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_LEFT:   wl_r <= pwdata[W-1:0];
        REG_TOP:    wt_r <= pwdata[W-1:0];
        REG_RIGHT:  wr_r <= pwdata[W-1:0];
        REG_BOTTOM: wb_r <= pwdata[W-1:0];
        default:    wl_r <= wl_r;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_LEFT:   prdata = 32'(wl_r);
      REG_TOP:    prdata = 32'(wt_r);
      REG_RIGHT:  prdata = 32'(wr_r);
      REG_BOTTOM: prdata = 32'(wb_r);
      default:    prdata = '0;
    endcase
  end

  // outcodes and products
  lwc_prep #(.W(W)) u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .vld_i  (in_valid),
    .sx_i   (in_start_x),
    .sy_i   (in_start_y),
    .ex_i   (in_end_x),
    .ey_i   (in_end_y),
    .wl_i   (wl_r),
    .wt_i   (wt_r),
    .wr_i   (wr_r),
    .wb_i   (wb_r),
    .vld_o  (pv),
    .prod_o (pprod),
    .div_o  (pdiv),
    .neg_o  (pneg),
    .zero_o (pzero),
    .c1_o   (pc1),
    .c2_o   (pc2),
    .pts_o  (ppts)
  );

  // chain entry
  always_comb begin
    ch_vld[0] = pv;
    for (int k = 0; k < 4; k++) begin
      ch_rem[0][k] = pprod[k][2*W-1:W];
      ch_low[0][k] = pprod[k][W-1:0];
    end
    ch_div[0] = pdiv;
    ch_sb[0]  = {ppts, pc1, pc2, pneg, pzero};
  end

  // one cell per quotient bit
  for (genvar g = 0; g < W; g++) begin : g_cell
    lwc_cell #(.W(W), .SB_BITS(SB_BITS)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .vld_i (ch_vld[g]),
      .rem_i (ch_rem[g]),
      .low_i (ch_low[g]),
      .div_i (ch_div[g]),
      .sb_i  (ch_sb[g]),
      .vld_o (ch_vld[g+1]),
      .rem_o (ch_rem[g+1]),
      .low_o (ch_low[g+1]),
      .div_o (ch_div[g+1]),
      .sb_o  (ch_sb[g+1])
    );
  end

  // signed quotients, endpoint moves and verdict
  always_comb begin
    logic [4*W-1:0]    pts;
    logic [3:0]        c1, c2, neg, zero, cd, nc0, nc1;
    logic signed [W:0] qs [4];
    wide_t             px, py, xe, ye, ynew, xnew, nx, ny;
    wide_t             nsx, nsy, nex, ney;
    wide_t             wl, wt, wr, wb;
    {pts, c1, c2, neg, zero} = ch_sb[W];
    wl = WIDE_BITS'(wl_r);
    wt = WIDE_BITS'(wt_r);
    wr = WIDE_BITS'(wr_r);
    wb = WIDE_BITS'(wb_r);
    for (int k = 0; k < 4; k++) begin
      if (zero[k])     qs[k] = '0;
      else if (neg[k]) qs[k] = -$signed({1'b0, ch_low[W][k]});
      else             qs[k] = $signed({1'b0, ch_low[W][k]});
    end
    nsx = '0; nsy = '0; nex = '0; ney = '0;
    for (int e = 0; e < 2; e++) begin
      if (e == 0) begin
        px = WIDE_BITS'($signed(pts[4*W-1:3*W]));
        py = WIDE_BITS'($signed(pts[3*W-1:2*W]));
        cd = c1;
      end else begin
        px = WIDE_BITS'($signed(pts[2*W-1:W]));
        py = WIDE_BITS'($signed(pts[W-1:0]));
        cd = c2;
      end
      xe   = cd[CODE_RIGHT]  ? wr : wl;
      ye   = cd[CODE_BOTTOM] ? wb : wt;
      ynew = py + WIDE_BITS'(qs[2*e]);
      xnew = px + WIDE_BITS'(qs[2*e+1]);
      nx = px;
      ny = py;
      if ((cd[CODE_LEFT] || cd[CODE_RIGHT]) && ynew <= wb && ynew >= wt) begin
        nx = xe;
        ny = ynew;
      end else if (cd[CODE_TOP] || cd[CODE_BOTTOM]) begin
        nx = xnew;
        ny = ye;
      end
      if (e == 0) begin
        nsx = nx; nsy = ny;
      end else begin
        nex = nx; ney = ny;
      end
    end
    nc0 = outcode(nsx, nsy, wl, wt, wr, wb);
    nc1 = outcode(nex, ney, wl, wt, wr, wb);
    if ((c1 | c2) == '0) begin
      verdict_nxt = VERDICT_ACCEPT;
      {osx_nxt, osy_nxt, oex_nxt, oey_nxt} = pts;
    end else if ((c1 & c2) == '0 && (nc0 | nc1) == '0) begin
      verdict_nxt = VERDICT_CLIPPED;
      osx_nxt = nsx[W-1:0];
      osy_nxt = nsy[W-1:0];
      oex_nxt = nex[W-1:0];
      oey_nxt = ney[W-1:0];
    end else begin
      verdict_nxt = VERDICT_REJECT;
      osx_nxt = '0;
      osy_nxt = '0;
      oex_nxt = '0;
      oey_nxt = '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ch_vld[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      verdict_r <= verdict_nxt;
      osx_r     <= osx_nxt;
      osy_r     <= osy_nxt;
      oex_r     <= oex_nxt;
      oey_r     <= oey_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_verdict     = verdict_r;
  assign out_out_start_x = osx_r;
  assign out_out_start_y = osy_r;
  assign out_out_end_x   = oex_r;
  assign out_out_end_y   = oey_r;

endmodule

// File: verif/lwc_checker.sv
// result checker for the line window clipper: predicts each segment and compares
`timescale 1ns / 100ps
module lwc_checker #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [1:0]                   out_verdict,
  input  logic signed [COORD_BITS-1:0] out_out_start_x,
  input  logic signed [COORD_BITS-1:0] out_out_start_y,
  input  logic signed [COORD_BITS-1:0] out_out_end_x,
  input  logic signed [COORD_BITS-1:0] out_out_end_y,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [3:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output int                           errors,
  output int                           pending
);
  import lwc_pkg::*;

  typedef logic signed [63:0] s64_t;
  typedef struct packed {
    verdict_t                verdict;
    logic [COORD_BITS-1:0]   sx, sy, ex, ey;
  } clip_t;

  clip_t clip_q[$];
  s64_t win_l, win_t, win_r, win_b;

  function automatic logic [3:0] region(s64_t x, s64_t y);
    logic [3:0] c;
    c = '0;
    c[CODE_TOP]    = y < win_t;
    c[CODE_BOTTOM] = y > win_b;
    c[CODE_RIGHT]  = x > win_r;
    c[CODE_LEFT]   = x < win_l;
    return c;
  endfunction

  // scaled offset, truncated toward zero, zero divisor gives zero
  function automatic s64_t scaled(s64_t a, s64_t b, s64_t c);
    if (c == 0) return 0;
    return (a * b) / c;
  endfunction

  // move one outside endpoint onto the window edge, using the original segment
  function automatic void move_end(s64_t px, s64_t py, s64_t ox, s64_t oy,
                                   logic [3:0] c, output s64_t nx, output s64_t ny);
    s64_t xe, ye, yy;
    nx = px;
    ny = py;
    if (c[CODE_LEFT] || c[CODE_RIGHT]) begin
      xe = c[CODE_RIGHT] ? win_r : win_l;
      yy = py + scaled(oy - py, xe - px, ox - px);
      if (yy <= win_b && yy >= win_t) begin
        nx = xe;
        ny = yy;
        return;
      end
    end
    if (c[CODE_TOP] || c[CODE_BOTTOM]) begin
      ye = c[CODE_BOTTOM] ? win_b : win_t;
      nx = px + scaled(ox - px, ye - py, oy - py);
      ny = ye;
    end
  endfunction

  function automatic clip_t clip_segment(s64_t sx, s64_t sy, s64_t ex, s64_t ey);
    clip_t r;
    logic [3:0] c1, c2;
    s64_t nsx, nsy, nex, ney;
    c1 = region(sx, sy);
    c2 = region(ex, ey);
    r = '0;
    r.verdict = VERDICT_REJECT;
    if ((c1 | c2) == 0) begin
      r.verdict = VERDICT_ACCEPT;
      r.sx = COORD_BITS'(sx); r.sy = COORD_BITS'(sy);
      r.ex = COORD_BITS'(ex); r.ey = COORD_BITS'(ey);
    end else if ((c1 & c2) == 0) begin
      move_end(sx, sy, ex, ey, c1, nsx, nsy);
      move_end(ex, ey, sx, sy, c2, nex, ney);
      if ((region(nsx, nsy) | region(nex, ney)) == 0) begin
        r.verdict = VERDICT_CLIPPED;
        r.sx = COORD_BITS'(nsx); r.sy = COORD_BITS'(nsy);
        r.ex = COORD_BITS'(nex); r.ey = COORD_BITS'(ney);
      end
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  assign pending = clip_q.size();

  always @(posedge clk) begin
    clip_t want;
    if (!rst_n) begin
      errors <= 0;
      clip_q.delete();
      win_l = WIN_LEFT_RST; win_t = WIN_TOP_RST;
      win_r = WIN_RIGHT_RST; win_b = WIN_BOTTOM_RST;
    end else begin
      // register write
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_LEFT:   win_l = s64_t'($signed(pwdata[COORD_BITS-1:0]));
          REG_TOP:    win_t = s64_t'($signed(pwdata[COORD_BITS-1:0]));
          REG_RIGHT:  win_r = s64_t'($signed(pwdata[COORD_BITS-1:0]));
          REG_BOTTOM: win_b = s64_t'($signed(pwdata[COORD_BITS-1:0]));
          default: ;
        endcase
      end
      // input transaction
      if (in_valid && !in_stall)
        clip_q.push_back(clip_segment(s64_t'(in_start_x), s64_t'(in_start_y),
                                      s64_t'(in_end_x), s64_t'(in_end_y)));
      // result transaction
      if (out_valid && !out_stall) begin
        if (clip_q.size() == 0) begin
          $display("unexpected result at %0t", $time);
          errors++;
        end else begin
          want = clip_q.pop_front();
          if (out_verdict !== want.verdict)
            report("verdict", 32'(out_verdict), 32'(want.verdict));
          if (out_out_start_x !== want.sx)
            report("start_x", 32'(out_out_start_x), 32'(want.sx));
          if (out_out_start_y !== want.sy)
            report("start_y", 32'(out_out_start_y), 32'(want.sy));
          if (out_out_end_x !== want.ex)
            report("end_x", 32'(out_out_end_x), 32'(want.ex));
          if (out_out_end_y !== want.ey)
            report("end_y", 32'(out_out_end_y), 32'(want.ey));
        end
      end
    end
  end
endmodule

// File: verif/tb.sv
// testbench top for the line window clipper: stimulus, register setup and verdict
`timescale 1ns / 100ps
module tb;
  import lwc_pkg::*;
  localparam int CB = 16;
  localparam int LAT = CB + 3;
  localparam int LIMIT = 400000;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic signed [CB-1:0] in_start_x = 0, in_start_y = 0, in_end_x = 0, in_end_y = 0;
  logic [1:0] out_verdict;
  logic signed [CB-1:0] o_sx, o_sy, o_ex, o_ey;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  int errors, pending, cycles = 0;
  int busy_pct = 30;

  always #4 clk = ~clk;

  line_window_clipper_core #(.COORD_BITS(CB)) u_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_start_x, .in_start_y, .in_end_x,
    .in_end_y, .out_valid, .out_stall, .out_verdict, .out_out_start_x(o_sx),
    .out_out_start_y(o_sy), .out_out_end_x(o_ex), .out_out_end_y(o_ey),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready);

  lwc_checker #(.COORD_BITS(CB)) u_chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_start_x, .in_start_y, .in_end_x,
    .in_end_y, .out_valid, .out_stall, .out_verdict, .out_out_start_x(o_sx),
    .out_out_start_y(o_sy), .out_out_end_x(o_ex), .out_out_end_y(o_ey),
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .errors, .pending);

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[line_window_clipper_core] ERROR");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) out_stall <= ($urandom_range(99) < busy_pct);

  task automatic write_reg(reg_idx_t idx, logic signed [CB-1:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00};
    pwdata <= {{(32-CB){v[CB-1]}}, v};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic set_window(int l, int t, int r, int b);
    write_reg(REG_LEFT, CB'(l));
    write_reg(REG_TOP, CB'(t));
    write_reg(REG_RIGHT, CB'(r));
    write_reg(REG_BOTTOM, CB'(b));
  endtask

  // one segment transaction, with a random gap before it
  task automatic send_segment(int sx, int sy, int ex, int ey);
    while ($urandom_range(99) < busy_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_start_x <= CB'(sx); in_start_y <= CB'(sy);
    in_end_x <= CB'(ex); in_end_y <= CB'(ey);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  // coordinate near the window or anywhere
  function automatic int pick(int lo, int hi);
    case ($urandom_range(3))
      0: return $signed(16'($urandom()));
      1: return lo + $signed(5'($urandom())) ;
      2: return hi + $signed(5'($urandom()));
      default: return $signed(16'(lo + $urandom_range(0, 2 * (hi - lo + 40)) - 40));
    endcase
  endfunction

  int wins[6][4] = '{'{0, 0, 639, 479}, '{-100, -50, 100, 50},
                     '{-32768, -32768, 32767, 32767}, '{32767, 32767, -32768, -32768},
                     '{5, 5, 5, 5}, '{-2000, 300, 1500, 9000}};

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset window, extremes, each verdict, inverted window later
    send_segment(10, 10, 600, 400);
    send_segment(-50, 240, 700, 240);
    send_segment(-10, -10, -5, -20);
    send_segment(320, -100, 320, 600);
    send_segment(-32768, -32768, 32767, 32767);
    send_segment(32767, -32768, -32768, 32767);
    send_segment(0, 0, 639, 479);
    send_segment(-1, 500, 700, -30);
    send_segment(100, 100, 100, 100);
    send_segment(-32768, 0, -32768, 479);
    send_segment(-20, 470, 30, 530);
    send_segment(32767, 32767, 32767, 32767);
    drain();

    for (int w = 1; w < 6; w++) begin
      set_window(wins[w][0], wins[w][1], wins[w][2], wins[w][3]);
      busy_pct = (w == 3) ? 0 : 30;
      for (int i = 0; i < 130; i++) begin
        int l, r, t, b;
        l = wins[w][0]; r = wins[w][2]; t = wins[w][1]; b = wins[w][3];
        if (l > r) begin l = r; r = wins[w][0]; end
        if (t > b) begin t = b; b = wins[w][1]; end
        send_segment(pick(l, r), pick(t, b), pick(l, r), pick(t, b));
      end
      drain();
    end
    busy_pct = 30;
    set_window(0, 0, 639, 479);
    for (int i = 0; i < 50; i++)
      send_segment(pick(0, 639), pick(0, 479), pick(0, 639), pick(0, 479));
    drain();

    if (errors == 0)
      $display("[line_window_clipper_core] OK");
    else
      $display("[line_window_clipper_core] ERROR");
    $finish;
  end
endmodule

// File: files.f
sv/lwc_pkg.sv
sv/lwc_cell.sv
sv/lwc_prep.sv
sv/line_window_clipper_core.sv
verif/lwc_checker.sv
verif/tb.sv
